/* rtl/core/xmodem_checksum_receiver_macros.svh */
// assertion macros for the xmodem checksum receiver
// no dependencies; included by modules that carry concurrent checks
`ifndef XMODEM_CHECKSUM_RECEIVER_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define XCR_ASSERT_ALWAYS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// consequence holds in the same cycle as the trigger
`define XCR_ASSERT_IMPLIES(name, clk, rst, trig, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("implication violated");

// consequence holds in the cycle after the trigger
`define XCR_ASSERT_NEXT(name, clk, rst, trig, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define XCR_ASSERT_ALWAYS(name, clk, rst, cond)
`define XCR_ASSERT_IMPLIES(name, clk, rst, trig, cons)
`define XCR_ASSERT_NEXT(name, clk, rst, trig, cons)

`endif

`endif

/* rtl/core/xcr_pkg.sv */
// shared types, codes and constants of the xmodem checksum receiver
// no dependencies; imported by the top level
package xcr_pkg;

  // defaults
  localparam int PACKET_BYTES_DEF = 132;
  localparam int FIFO_DEPTH_DEF   = 4;

  // configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INCOMPLETE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TICKS        = 1'b1;
  localparam logic [CFG_W-1:0] INCOMPLETE_TICKS_RST = 12'd1200;
  localparam logic [CFG_W-1:0] END_TICKS_RST        = 12'd240;

  // link codes
  localparam logic [7:0] ACK_CODE = 8'h06;
  localparam logic [7:0] NAK_CODE = 8'h15;
  localparam logic [7:0] EOT_CODE = 8'h04;
  localparam logic [7:0] CAN_CODE = 8'h18;

  // input commands
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_PULL = 2'd2;

  // led modes
  localparam logic [2:0] LED_NONE      = 3'd0;
  localparam logic [2:0] LED_BLINK_1HZ = 3'd1;
  localparam logic [2:0] LED_BLINK_2HZ = 3'd2;
  localparam logic [2:0] LED_STANDBY   = 3'd3;
  localparam logic [2:0] LED_NORMAL    = 3'd4;

  localparam logic [1:0] RETRY_MAX = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic       display_empty;
  } in_item_t;

  typedef struct packed {
    logic       link_valid;
    logic [7:0] link_byte;
    logic       display_valid;
    logic [7:0] display_byte;
    logic [2:0] led_mode;
    logic [1:0] retry_count;
    logic       last_of_run;
  } out_item_t;

  // reply or led result with no display byte
  function automatic out_item_t reply(input logic lv, input logic [7:0] lb,
                                      input logic [2:0] led, input logic [1:0] retry);
    out_item_t r;
    r = '0;
    r.link_valid  = lv;
    r.link_byte   = lb;
    r.led_mode    = led;
    r.retry_count = retry;
    return r;
  endfunction

endpackage

/* rtl/core/xcr_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module xcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/xmodem_checksum_receiver.sv */
// xmodem checksum receiver: packet collection, validation, drain and timers.
// path: an item's results pass from the state stage through the ram read / result stage
// into a 4-entry output buffer.
// throughput: one item per cycle; in_ready drops only while the output buffer
// plus the result stage could not take two more results.
// reset: synchronous, clears all control state and loads register defaults;
// the packet ram is not cleared and needs no clearing pass.
module xmodem_checksum_receiver #(
  parameter int PACKET_BYTES = xcr_pkg::PACKET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  xcr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output xcr_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [xcr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xcr_pkg::CFG_W-1:0]      cfg_data
);
  import xcr_pkg::*;

`include "xmodem_checksum_receiver_macros.svh"

  localparam int FIFO_DEPTH    = FIFO_DEPTH_DEF;
  localparam int PAYLOAD_BYTES = PACKET_BYTES - 4;
  localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);
  localparam int FILL_W        = $clog2(PACKET_BYTES + 1);
  localparam int DRAIN_W       = $clog2(PAYLOAD_BYTES + 1);
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int COUNT_W       = $clog2(FIFO_DEPTH + 1);

  // configuration registers
  logic [CFG_W-1:0] incomplete_ticks;
  logic [CFG_W-1:0] end_ticks;

  // receiver state
  logic               draining,          draining_next;
  logic [FILL_W-1:0]  fill_count,        fill_count_next;
  logic [7:0]         first_byte,        first_byte_next;
  logic [7:0]         seq_byte,          seq_byte_next;
  logic [7:0]         seq_complement,    seq_complement_next;
  logic [7:0]         expected_last_seq, expected_last_seq_next;
  logic [7:0]         running_sum,       running_sum_next;
  logic               idle_flag,         idle_flag_next;
  logic [1:0]         retries,           retries_next;
  logic [CFG_W-1:0]   incomplete_timer,  incomplete_timer_next;
  logic               incomplete_armed,  incomplete_armed_next;
  logic [CFG_W-1:0]   end_timer,         end_timer_next;
  logic               end_armed,         end_armed_next;
  logic [DRAIN_W-1:0] drain_index,       drain_index_next;

  // stage-0 results
  logic       in_fire;
  logic [1:0] res_n;
  out_item_t  res0, res1;
  logic       res_disp;

  // packet ram
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [FILL_W-1:0] store_off;
  logic [7:0]        mem_rdata;

  // result stage
  logic [1:0] s1_n;
  out_item_t  s1_r0, s1_r1, s1_e0;
  logic       s1_disp;

  // output buffer
  out_item_t          fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] fifo_count;
  logic               pop;

  assign in_fire   = in_valid && in_ready;
  assign store_off = fill_count - FILL_W'(3);
  assign mem_waddr = store_off[ADDR_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      incomplete_ticks <= INCOMPLETE_TICKS_RST;
      end_ticks        <= END_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INCOMPLETE_TICKS: incomplete_ticks <= cfg_data;
        CFG_END_TICKS:        end_ticks        <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-item state update and result generation
  always_comb begin
    logic [1:0]        retries_cur;
    logic [FILL_W-1:0] fill_cur;
    logic [2:0]        led_inc;
    logic [CFG_W-1:0]  it_dec;
    logic [CFG_W-1:0]  et_dec;
    out_item_t         end_res;

    draining_next          = draining;
    fill_count_next        = fill_count;
    first_byte_next        = first_byte;
    seq_byte_next          = seq_byte;
    seq_complement_next    = seq_complement;
    expected_last_seq_next = expected_last_seq;
    running_sum_next       = running_sum;
    idle_flag_next         = idle_flag;
    retries_next           = retries;
    incomplete_timer_next  = incomplete_timer;
    incomplete_armed_next  = incomplete_armed;
    end_timer_next         = end_timer;
    end_armed_next         = end_armed;
    drain_index_next       = drain_index;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    res_n    = 2'd0;
    res0     = '0;
    res1     = '0;
    res_disp = 1'b0;
    retries_cur = retries;
    fill_cur    = fill_count;
    led_inc     = LED_NONE;
    end_res     = '0;

    // timers count down only while armed and above zero
    it_dec = (incomplete_armed && incomplete_timer != '0) ?
             incomplete_timer - CFG_W'(1) : incomplete_timer;
    et_dec = (end_armed && end_timer != '0) ? end_timer - CFG_W'(1) : end_timer;

    if (in_fire) begin
      case (in_data.cmd)
        CMD_BYTE: begin
          if (!draining) begin
            // header, payload or checksum byte
            if (fill_count == FILL_W'(0)) begin
              first_byte_next = in_data.rx_byte;
            end else if (fill_count == FILL_W'(1)) begin
              seq_byte_next = in_data.rx_byte;
            end else if (fill_count == FILL_W'(2)) begin
              seq_complement_next = in_data.rx_byte;
            end else if (fill_count < FILL_W'(PACKET_BYTES - 1)) begin
              mem_we           = 1'b1;
              running_sum_next = running_sum + in_data.rx_byte;
            end
            fill_count_next       = fill_count + FILL_W'(1);
            incomplete_timer_next = incomplete_ticks;
            incomplete_armed_next = 1'b1;
            end_timer_next        = end_ticks;
            end_armed_next        = 1'b1;
            // checksum byte completes the packet
            if (fill_count == FILL_W'(PACKET_BYTES - 1)) begin
              fill_count_next  = '0;
              running_sum_next = '0;
              idle_flag_next   = 1'b0;
              retries_next     = 2'd0;
              res_n            = 2'd1;
              if (seq_byte == expected_last_seq + 8'd1 && seq_complement == ~seq_byte) begin
                if (running_sum == in_data.rx_byte) begin
                  expected_last_seq_next = seq_byte;
                  draining_next          = 1'b1;
                  drain_index_next       = '0;
                  res0 = reply(1'b0, 8'h00, LED_NORMAL, 2'd0);
                end else begin
                  res0 = reply(1'b1, NAK_CODE, LED_NONE, 2'd0);
                end
              end else if (seq_byte == expected_last_seq) begin
                res0 = reply(1'b1, ACK_CODE, LED_NONE, 2'd0);
              end else begin
                res0 = reply(1'b1, NAK_CODE, LED_NONE, 2'd0);
              end
            end
          end
        end
        CMD_TICK: begin
          incomplete_timer_next = it_dec;
          end_timer_next        = et_dec;
          if (!draining) begin
            // long silence
            if (incomplete_armed && it_dec == '0) begin
              res_n = 2'd1;
              if (idle_flag) begin
                incomplete_armed_next = 1'b0;
                res0 = reply(1'b1, NAK_CODE, LED_NONE, retries);
              end else begin
                incomplete_timer_next = incomplete_ticks;
                fill_count_next       = '0;
                running_sum_next      = '0;
                fill_cur              = '0;
                if (retries < RETRY_MAX) begin
                  retries_cur = retries + 2'd1;
                  if (retries_cur == 2'd2) begin
                    led_inc = LED_BLINK_2HZ;
                  end
                end
                retries_next = retries_cur;
                res0 = reply(1'b1, NAK_CODE, led_inc, retries_cur);
              end
            end
            // short silence: end-of-transfer check
            if (end_armed && et_dec == '0 && !idle_flag && in_data.display_empty) begin
              end_armed_next = 1'b0;
              if (fill_cur != '0 && (first_byte == EOT_CODE || first_byte == CAN_CODE)) begin
                fill_count_next        = '0;
                running_sum_next       = '0;
                incomplete_armed_next  = 1'b0;
                incomplete_timer_next  = '0;
                idle_flag_next         = 1'b1;
                seq_byte_next          = '0;
                seq_complement_next    = '0;
                expected_last_seq_next = '0;
                retries_next           = 2'd0;
                end_res = reply(1'b1, ACK_CODE, LED_STANDBY, 2'd0);
              end else begin
                end_res = reply(1'b0, 8'h00, LED_BLINK_1HZ, retries_cur);
              end
              if (res_n == 2'd0) begin
                res0 = end_res;
              end else begin
                res1 = end_res;
              end
              res_n = res_n + 2'd1;
            end
          end
        end
        CMD_PULL: begin
          if (draining) begin
            res_n = 2'd1;
            if (drain_index < DRAIN_W'(PAYLOAD_BYTES)) begin
              mem_re   = 1'b1;
              res_disp = 1'b1;
              drain_index_next = drain_index + DRAIN_W'(1);
              res0 = reply(1'b0, 8'h00, LED_NONE, retries);
              res0.display_valid = 1'b1;
            end else begin
              draining_next    = 1'b0;
              drain_index_next = '0;
              fill_count_next  = '0;
              running_sum_next = '0;
              retries_next     = 2'd0;
              idle_flag_next   = 1'b0;
              res0 = reply(1'b1, ACK_CODE, LED_NONE, 2'd0);
            end
          end
        end
        default: ;
      endcase
    end

    // mark the final result of the item
    if (res_n == 2'd1) begin
      res0.last_of_run = 1'b1;
    end else if (res_n == 2'd2) begin
      res1.last_of_run = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      draining          <= 1'b0;
      fill_count        <= '0;
      first_byte        <= '0;
      seq_byte          <= '0;
      seq_complement    <= '0;
      expected_last_seq <= '0;
      running_sum       <= '0;
      idle_flag         <= 1'b1;
      retries           <= 2'd0;
      incomplete_timer  <= '0;
      incomplete_armed  <= 1'b0;
      end_timer         <= '0;
      end_armed         <= 1'b0;
      drain_index       <= '0;
    end else begin
      draining          <= draining_next;
      fill_count        <= fill_count_next;
      first_byte        <= first_byte_next;
      seq_byte          <= seq_byte_next;
      seq_complement    <= seq_complement_next;
      expected_last_seq <= expected_last_seq_next;
      running_sum       <= running_sum_next;
      idle_flag         <= idle_flag_next;
      retries           <= retries_next;
      incomplete_timer  <= incomplete_timer_next;
      incomplete_armed  <= incomplete_armed_next;
      end_timer         <= end_timer_next;
      end_armed         <= end_armed_next;
      drain_index       <= drain_index_next;
    end
  end

  // payload store; writes only while receiving, reads only while draining
  xcr_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(in_data.rx_byte),
    .re   (mem_re),
    .raddr(drain_index[ADDR_W-1:0]),
    .rdata(mem_rdata)
  );

  // result stage, waits for the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_n    <= 2'd0;
      s1_disp <= 1'b0;
    end else begin
      s1_n    <= in_fire ? res_n : 2'd0;
      s1_disp <= in_fire && res_disp;
    end
  end

  always_ff @(posedge clk) begin
    s1_r0 <= res0;
    s1_r1 <= res1;
  end

  always_comb begin
    s1_e0 = s1_r0;
    if (s1_disp) begin
      s1_e0.display_byte = mem_rdata;
    end
  end

  // output buffer, up to two results pushed per cycle
  assign pop       = out_valid && out_ready;
  assign out_valid = fifo_count != '0;
  assign out_data  = fifo_mem[rd_ptr];
  assign in_ready  = (fifo_count + COUNT_W'(s1_n)) <= COUNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (s1_n != 2'd0) begin
      fifo_mem[wr_ptr] <= s1_e0;
    end
    if (s1_n == 2'd2) begin
      fifo_mem[wr_ptr + PTR_W'(1)] <= s1_r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      wr_ptr     <= wr_ptr + PTR_W'(s1_n);
      rd_ptr     <= rd_ptr + PTR_W'(pop);
      fifo_count <= fifo_count + COUNT_W'(s1_n) - COUNT_W'(pop);
    end
  end

  // checks
  `XCR_ASSERT_ALWAYS(a_buffer_room, clk, rst, (fifo_count + COUNT_W'(s1_n)) <= COUNT_W'(FIFO_DEPTH))
  `XCR_ASSERT_IMPLIES(a_drain_no_fill, clk, rst, draining, fill_count == '0)
  `XCR_ASSERT_IMPLIES(a_no_store_in_drain, clk, rst, mem_we, !draining && !mem_re)
  `XCR_ASSERT_NEXT(a_pull_reaches_stage, clk, rst, mem_re, s1_disp && s1_n == 2'd1)

endmodule

/* tb/tb_xmodem_checksum_receiver.sv */
// self-checking testbench of the xmodem checksum receiver: packets, drain, timers
// depends on xcr_pkg and the xmodem_checksum_receiver rtl; results are predicted by a
// behavioral copy of the receiver kept in this module and checked on the output channel
module tb_xmodem_checksum_receiver;
  import xcr_pkg::*;

  localparam int PAYLOAD_BYTES = PACKET_BYTES_DEF - 4;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] SOH_CODE = 8'h01;
  // extra wait for the pipeline and the output buffer after the last result
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int mismatches = 0;
  int items_sent = 0;
  bit quiet_idle = 1'b0;

  xmodem_checksum_receiver dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver predictor state
  // ---------------------------------------------------------------------------
  logic [11:0] incomplete_ticks = INCOMPLETE_TICKS_RST;
  logic [11:0] end_ticks = END_TICKS_RST;
  bit          drain_on = 1'b0;
  logic [7:0]  fill_cnt = '0;
  logic [7:0]  payload_mem [0:PAYLOAD_BYTES-1];
  logic [7:0]  seen_lead = '0;
  logic [7:0]  seen_seq = '0;
  logic [7:0]  seen_inv = '0;
  logic [7:0]  acked_seq = '0;
  logic [7:0]  payload_sum = '0;
  logic [7:0]  sum_field = '0;
  bit          awaiting_start = 1'b1;
  logic [1:0]  retries_now = '0;
  logic [11:0] silence_timer = '0;
  bit          silence_armed = 1'b0;
  logic [11:0] end_timer = '0;
  bit          end_armed = 1'b0;
  logic [7:0]  drain_idx = '0;

  out_item_t awaited_results [$];

  task automatic queue_result(input bit lv, input logic [7:0] lb, input bit dv,
                              input logic [7:0] db, input logic [2:0] led);
    out_item_t r;
    r.link_valid    = lv;
    r.link_byte     = lb;
    r.display_valid = dv;
    r.display_byte  = db;
    r.led_mode      = led;
    r.retry_count   = retries_now;
    r.last_of_run   = 1'b0;
    awaited_results.push_back(r);
  endtask

  // advance the receiver copy by one transfer and queue what it emits
  task automatic predict_results(input in_item_t it);
    int unsigned prior_n;
    logic [7:0] next_seq;
    logic [7:0] sum_now;
    logic [2:0] led;
    out_item_t r;
    prior_n = awaited_results.size();
    case (it.cmd)
      CMD_BYTE: begin
        // link bytes are dropped while the payload drains
        if (!drain_on) begin
          if (fill_cnt == 0) seen_lead = it.rx_byte;
          else if (fill_cnt == 1) seen_seq = it.rx_byte;
          else if (fill_cnt == 2) seen_inv = it.rx_byte;
          else if (fill_cnt < PACKET_BYTES_DEF - 1) begin
            payload_mem[fill_cnt - 8'd3] = it.rx_byte;
            payload_sum = payload_sum + it.rx_byte;
          end else sum_field = it.rx_byte;
          fill_cnt++;
          silence_timer = incomplete_ticks;
          silence_armed = 1'b1;
          end_timer = end_ticks;
          end_armed = 1'b1;
          // packet complete: validate sequence, complement and sum
          if (fill_cnt >= PACKET_BYTES_DEF) begin
            next_seq = acked_seq + 8'd1;
            sum_now = payload_sum;
            fill_cnt = '0;
            payload_sum = '0;
            awaiting_start = 1'b0;
            retries_now = '0;
            if (seen_seq == next_seq && seen_inv == ~seen_seq) begin
              if (sum_now == sum_field) begin
                acked_seq = seen_seq;
                drain_on = 1'b1;
                drain_idx = '0;
                queue_result(1'b0, 8'h00, 1'b0, 8'h00, LED_NORMAL);
              end else begin
                queue_result(1'b1, NAK_CODE, 1'b0, 8'h00, LED_NONE);
              end
            end else if (seen_seq == acked_seq) begin
              queue_result(1'b1, ACK_CODE, 1'b0, 8'h00, LED_NONE);
            end else begin
              queue_result(1'b1, NAK_CODE, 1'b0, 8'h00, LED_NONE);
            end
          end
        end
      end
      CMD_TICK: begin
        // timers run while draining, expiries wait for receive mode
        if (silence_armed && silence_timer != 0) silence_timer--;
        if (end_armed && end_timer != 0) end_timer--;
        if (!drain_on) begin
          if (silence_armed && silence_timer == 0) begin
            if (awaiting_start) begin
              silence_armed = 1'b0;
              queue_result(1'b1, NAK_CODE, 1'b0, 8'h00, LED_NONE);
            end else begin
              led = LED_NONE;
              silence_timer = incomplete_ticks;
              fill_cnt = '0;
              payload_sum = '0;
              if (retries_now < RETRY_MAX) begin
                retries_now++;
                if (retries_now == 2) led = LED_BLINK_2HZ;
              end
              queue_result(1'b1, NAK_CODE, 1'b0, 8'h00, led);
            end
          end
          if (end_armed && end_timer == 0 && !awaiting_start && it.display_empty) begin
            end_armed = 1'b0;
            if (fill_cnt > 0 && (seen_lead == EOT_CODE || seen_lead == CAN_CODE)) begin
              fill_cnt = '0;
              payload_sum = '0;
              silence_armed = 1'b0;
              silence_timer = '0;
              awaiting_start = 1'b1;
              seen_seq = '0;
              seen_inv = '0;
              acked_seq = '0;
              retries_now = '0;
              queue_result(1'b1, ACK_CODE, 1'b0, 8'h00, LED_STANDBY);
            end else begin
              queue_result(1'b0, 8'h00, 1'b0, 8'h00, LED_BLINK_1HZ);
            end
          end
        end
      end
      CMD_PULL: begin
        if (drain_on) begin
          if (drain_idx < PAYLOAD_BYTES) begin
            queue_result(1'b0, 8'h00, 1'b1, payload_mem[drain_idx], LED_NONE);
            drain_idx++;
          end else begin
            // pull after the last payload byte closes the packet with ACK
            drain_on = 1'b0;
            drain_idx = '0;
            fill_cnt = '0;
            payload_sum = '0;
            retries_now = '0;
            awaiting_start = 1'b0;
            queue_result(1'b1, ACK_CODE, 1'b0, 8'h00, LED_NONE);
          end
        end
      end
      default: ;  // unused command is ignored
    endcase
    // flag the final result of this transfer
    if (awaited_results.size() > prior_n) begin
      r = awaited_results.pop_back();
      r.last_of_run = 1'b1;
      awaited_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    if (quiet_idle) return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 18) : 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [7:0] lead_byte();
    return ($urandom_range(0, 3) != 0) ? SOH_CODE : 8'($urandom);
  endfunction

  // one input transfer; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic empty);
    in_item_t it;
    int gap;
    it.cmd = cmd;
    it.rx_byte = data;
    it.display_empty = empty;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_results(it);
    items_sent++;
    @(negedge clk);
  endtask

  // idle the input and wait until every expected result has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_INCOMPLETE_TICKS) incomplete_ticks = value;
    else end_ticks = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // pull the payload out, with the odd tick or ignored link byte in between
  task automatic drain_payload();
    while (drain_on) begin
      case ($urandom_range(0, 15))
        0: send_item(CMD_TICK, 8'($urandom), 1'($urandom));
        1: send_item(CMD_BYTE, 8'($urandom), 1'($urandom));
        default: send_item(CMD_PULL, 8'($urandom), 1'($urandom));
      endcase
    end
  endtask

  // complete whatever partial packet is pending with random bytes
  task automatic flush_partial();
    while (!drain_on && fill_cnt != 0) send_item(CMD_BYTE, 8'($urandom), 1'($urandom));
    drain_payload();
  endtask

  task automatic send_packet(input logic [7:0] lead, input logic [7:0] seq,
                             input logic [7:0] inv, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    send_item(CMD_BYTE, lead, 1'($urandom));
    send_item(CMD_BYTE, seq, 1'($urandom));
    send_item(CMD_BYTE, inv, 1'($urandom));
    repeat (PAYLOAD_BYTES) begin
      b = 8'($urandom);
      sum = sum + b;
      send_item(CMD_BYTE, b, 1'($urandom));
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    send_item(CMD_BYTE, sum, 1'($urandom));
    drain_payload();
  endtask

  // single lead byte then silence until the end check fires
  task automatic end_transfer(input logic [7:0] lead);
    int guard;
    guard = 0;
    send_item(CMD_BYTE, lead, 1'($urandom));
    send_item(CMD_TICK, 8'($urandom), 1'b0);
    while (end_armed && guard < int'(end_ticks) + 4) begin
      send_item(CMD_TICK, 8'($urandom), 1'b1);
      guard++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // ignored commands, pulls while receiving, silence before any packet
  task automatic test_idle_commands();
    settle();
    write_reg(CFG_INCOMPLETE_TICKS, 12'd2);
    write_reg(CFG_END_TICKS, 12'd1);
    quiet_idle = 1'b0;
    send_item(CMD_UNUSED, 8'hff, 1'b1);
    send_item(CMD_PULL, 8'h00, 1'b0);
    send_item(CMD_TICK, 8'h00, 1'b0);
    send_item(CMD_BYTE, EOT_CODE, 1'b0);
    send_item(CMD_TICK, 8'hff, 1'b1);
    send_item(CMD_TICK, 8'h00, 1'b1);
    send_item(CMD_BYTE, 8'hff, 1'b1);
    send_item(CMD_BYTE, 8'h00, 1'b0);
    send_item(CMD_TICK, 8'h55, 1'b1);
    send_item(CMD_TICK, 8'haa, 1'b0);
    send_item(CMD_PULL, 8'hff, 1'b1);
    send_item(CMD_UNUSED, 8'h00, 1'b0);
  endtask

  // can closes the transfer, a good packet drains, any other lead byte only blinks
  task automatic test_end_of_transfer();
    settle();
    write_reg(CFG_INCOMPLETE_TICKS, 12'd4095);
    write_reg(CFG_END_TICKS, 12'd1);
    quiet_idle = 1'b0;
    flush_partial();
    end_transfer(CAN_CODE);
    send_packet(SOH_CODE, acked_seq + 8'd1, ~(acked_seq + 8'd1), 1'b0);
    end_transfer(SOH_CODE);
  endtask

  // retries climb and saturate, both timers expiring on one tick, eot closes
  task automatic test_silence_timeouts();
    settle();
    write_reg(CFG_INCOMPLETE_TICKS, 12'd1);
    write_reg(CFG_END_TICKS, 12'd4095);
    quiet_idle = 1'b0;
    repeat (5) send_item(CMD_BYTE, 8'($urandom), 1'($urandom));
    repeat (5) send_item(CMD_TICK, 8'($urandom), 1'($urandom));
    settle();
    write_reg(CFG_INCOMPLETE_TICKS, 12'd2);
    write_reg(CFG_END_TICKS, 12'd2);
    send_item(CMD_BYTE, SOH_CODE, 1'b0);
    send_item(CMD_TICK, 8'($urandom), 1'b1);
    send_item(CMD_TICK, 8'($urandom), 1'b1);
    settle();
    write_reg(CFG_INCOMPLETE_TICKS, 12'd4095);
    write_reg(CFG_END_TICKS, 12'd1);
    end_transfer(EOT_CODE);
  endtask

  // random mix of good and broken packets, silence, end checks and noise
  task automatic test_random_traffic();
    int stop_at;
    int kind;
    int guard;
    logic [7:0] seq;
    logic [7:0] pick;
    settle();
    write_reg(CFG_INCOMPLETE_TICKS, 12'($urandom_range(1, 40)));
    write_reg(CFG_END_TICKS, 12'($urandom_range(1, 40)));
    stop_at = items_sent + 150;
    while (items_sent < stop_at) begin
      quiet_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) flush_partial();
      seq = acked_seq + 8'd1;
      case (kind)
        0, 1, 2: send_packet(lead_byte(), seq, ~seq, 1'b0);
        // bad checksum on an in-sequence packet
        3: send_packet(lead_byte(), seq, ~seq, 1'b1);
        // bad complement
        4: send_packet(lead_byte(), seq, ~seq ^ 8'($urandom_range(1, 255)), 1'b0);
        // duplicate, complement and sum not looked at
        5: send_packet(lead_byte(), acked_seq, 8'($urandom), 1'($urandom));
        // out of sequence
        6: begin
          seq = acked_seq + 8'($urandom_range(2, 255));
          send_packet(lead_byte(), seq, ~seq, 1'b0);
        end
        // truncated packet left to time out
        7: begin
          guard = 0;
          repeat ($urandom_range(1, 12)) send_item(CMD_BYTE, 8'($urandom), 1'($urandom));
          while (fill_cnt != 0 && guard < int'(incomplete_ticks) + 4) begin
            send_item(CMD_TICK, 8'($urandom), 1'($urandom));
            guard++;
          end
        end
        8: begin
          case ($urandom_range(0, 2))
            0: pick = EOT_CODE;
            1: pick = CAN_CODE;
            default: pick = 8'($urandom);
          endcase
          end_transfer(pick);
        end
        default: begin
          repeat ($urandom_range(1, 8))
            send_item(2'($urandom), 8'($urandom), 1'($urandom));
        end
      endcase
    end
    quiet_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls on ready
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("link_valid", want.link_valid, out_data.link_valid);
        check_field("link_byte", want.link_byte, out_data.link_byte);
        check_field("display_valid", want.display_valid, out_data.display_valid);
        check_field("display_byte", want.display_byte, out_data.display_byte);
        check_field("led_mode", want.led_mode, out_data.led_mode);
        check_field("retry_count", want.retry_count, out_data.retry_count);
        check_field("last_of_run", want.last_of_run, out_data.last_of_run);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_INCOMPLETE_TICKS;
    cfg_data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_end_of_transfer();
    test_silence_timeouts();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
